FILE: rtl/gbei_pkg.sv
// ----------------------------------------------------------------------------
// gbei_pkg
// Shared types and constants for the gpio bank with edge interrupts: command
// and register codes, pin mask and the packed beat types of both channels.
// ----------------------------------------------------------------------------
package gbei_pkg;

  localparam int unsigned NUM_PINS = 32;
  localparam int unsigned DATA_W   = 32;

  // bits of pins that exist in this bank
  localparam logic [DATA_W-1:0] PIN_MASK =
    DATA_W'((64'd1 << NUM_PINS) - 64'd1);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // word index of each register (byte offset / 4)
  typedef enum logic [3:0] {
    REG_LEVEL     = 4'd0,
    REG_DIR       = 4'd1,
    REG_LATCH_SET = 4'd2,
    REG_LATCH_CLR = 4'd3,
    REG_RISE_EN   = 4'd4,
    REG_FALL_EN   = 4'd5,
    REG_STATUS    = 4'd6,
    REG_DIR_SET   = 4'd7,
    REG_DIR_CLR   = 4'd8,
    REG_RISE_SET  = 4'd9,
    REG_RISE_CLR  = 4'd10,
    REG_FALL_SET  = 4'd11,
    REG_FALL_CLR  = 4'd12,
    REG_IRQ_MASK  = 4'd13
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [3:0]        reg_index;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] pin_levels;
  } gbei_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] output_levels;
    logic [DATA_W-1:0] output_enables;
    logic              interrupt_request;
  } gbei_out_t;

endpackage

FILE: rtl/gpio_bank_edge_interrupt_top.sv
// ----------------------------------------------------------------------------
// gpio_bank_edge_interrupt_top
// One gpio bank taking bus accesses and pin-sample ticks, with set/clear
// aliases, write-one-to-clear edge status and a masked interrupt request.
//
//   channel   signals                      beat
//   input     in_valid / in_ready          in_data  (command, index, data, pins)
//   result    out_valid / out_ready        out_data (read data, pads, irq)
//
// The register bank updates at the accepting edge and the result lands in
// the output register at that same edge.
// A new beat is taken every cycle while the output register is empty or is
// being drained; only a held result with out_ready low stalls the input.
// Synchronous reset clears the register bank and empties the output register.
// ----------------------------------------------------------------------------
module gpio_bank_edge_interrupt_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gbei_pkg::gbei_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gbei_pkg::gbei_out_t out_data
);

  logic                accept;
  logic                out_valid_r;
  gbei_pkg::gbei_out_t out_data_r;
  gbei_pkg::gbei_out_t result;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  gbei_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (accept),
    .item   (in_data),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/gbei_regs.sv
// ----------------------------------------------------------------------------
// gbei_regs
// Register bank of the gpio block: latch, direction, edge enables, sticky
// edge status, interrupt mask and last pin sample. Updates on each accepted
// beat and builds that beat's result from the updated state.
// ----------------------------------------------------------------------------
module gbei_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  gbei_pkg::gbei_in_t  item,
  output gbei_pkg::gbei_out_t result
);

  logic [gbei_pkg::DATA_W-1:0] latch_r,  latch_nxt;
  logic [gbei_pkg::DATA_W-1:0] dir_r,    dir_nxt;
  logic [gbei_pkg::DATA_W-1:0] rise_r,   rise_nxt;
  logic [gbei_pkg::DATA_W-1:0] fall_r,   fall_nxt;
  logic [gbei_pkg::DATA_W-1:0] status_r, status_nxt;
  logic [gbei_pkg::DATA_W-1:0] mask_r,   mask_nxt;
  logic [gbei_pkg::DATA_W-1:0] last_r,   last_nxt;

  logic [gbei_pkg::DATA_W-1:0] wd;
  logic [gbei_pkg::DATA_W-1:0] lv;
  logic [gbei_pkg::DATA_W-1:0] rd;
  logic [gbei_pkg::DATA_W-1:0] edges;

  assign wd    = item.write_data & gbei_pkg::PIN_MASK;
  assign lv    = item.pin_levels & gbei_pkg::PIN_MASK;
  assign edges = ((lv & ~last_r) & rise_r) | ((~lv & last_r) & fall_r);

  always_comb begin
    latch_nxt  = latch_r;
    dir_nxt    = dir_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    status_nxt = status_r;
    mask_nxt   = mask_r;
    last_nxt   = last_r;
    rd         = '0;
    unique case (item.command)
      gbei_pkg::CMD_TICK: begin
        status_nxt = status_r | edges;
        last_nxt   = lv;
      end
      gbei_pkg::CMD_READ: begin
        unique case (item.reg_index)
          gbei_pkg::REG_LEVEL:    rd = last_r;
          gbei_pkg::REG_DIR:      rd = dir_r;
          gbei_pkg::REG_RISE_EN:  rd = rise_r;
          gbei_pkg::REG_FALL_EN:  rd = fall_r;
          gbei_pkg::REG_STATUS:   rd = status_r;
          gbei_pkg::REG_IRQ_MASK: rd = mask_r;
          default:                rd = '0;
        endcase
      end
      gbei_pkg::CMD_WRITE: begin
        unique case (item.reg_index)
          gbei_pkg::REG_DIR:       dir_nxt    = wd;
          gbei_pkg::REG_LATCH_SET: latch_nxt  = latch_r | wd;
          gbei_pkg::REG_LATCH_CLR: latch_nxt  = latch_r & ~wd;
          gbei_pkg::REG_RISE_EN:   rise_nxt   = wd;
          gbei_pkg::REG_FALL_EN:   fall_nxt   = wd;
          gbei_pkg::REG_STATUS:    status_nxt = status_r & ~wd;  // write one to clear
          gbei_pkg::REG_DIR_SET:   dir_nxt    = dir_r | wd;
          gbei_pkg::REG_DIR_CLR:   dir_nxt    = dir_r & ~wd;
          gbei_pkg::REG_RISE_SET:  rise_nxt   = rise_r | wd;
          gbei_pkg::REG_RISE_CLR:  rise_nxt   = rise_r & ~wd;
          gbei_pkg::REG_FALL_SET:  fall_nxt   = fall_r | wd;
          gbei_pkg::REG_FALL_CLR:  fall_nxt   = fall_r & ~wd;
          gbei_pkg::REG_IRQ_MASK:  mask_nxt   = wd;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r  <= '0;
      dir_r    <= '0;
      rise_r   <= '0;
      fall_r   <= '0;
      status_r <= '0;
      mask_r   <= '0;
      last_r   <= '0;
    end else if (en) begin
      latch_r  <= latch_nxt;
      dir_r    <= dir_nxt;
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
      status_r <= status_nxt;
      mask_r   <= mask_nxt;
      last_r   <= last_nxt;
    end
  end

  assign result.read_data         = rd;
  assign result.output_levels     = latch_nxt;
  assign result.output_enables    = dir_nxt;
  assign result.interrupt_request = |(status_nxt & mask_nxt);

endmodule

FILE: dv/gbei_checker.sv
// ----------------------------------------------------------------------------
// gbei_checker
// Watches both channels of the gpio bank, keeps its own copy of the register
// bank, predicts one result per accepted input beat and compares every
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module gbei_checker
  import gbei_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  gbei_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  gbei_out_t out_data,
  output int        mismatches,
  output int        waiting,
  output int        checked,
  output int        irq_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] latch_q, dir_q, rise_q, fall_q, status_q, mask_q, pins_q;
  gbei_out_t         due_results[$];
  int                bad_cnt;
  int                good_cnt;
  int                irq_cnt;

  // applies one beat to the local bank and returns the result it should give
  task automatic apply_to_bank(input gbei_in_t b, output gbei_out_t r);
    logic [DATA_W-1:0] wd;
    logic [DATA_W-1:0] lv;
    logic [DATA_W-1:0] rd;
    wd = b.write_data & PIN_MASK;
    lv = b.pin_levels & PIN_MASK;
    rd = '0;
    case (cmd_t'(b.command))
      CMD_TICK: begin
        status_q |= ((lv & ~pins_q & rise_q) | (~lv & pins_q & fall_q)) & PIN_MASK;
        pins_q = lv;
      end
      CMD_READ: begin
        case (reg_idx_t'(b.reg_index))
          REG_LEVEL:    rd = pins_q;
          REG_DIR:      rd = dir_q;
          REG_RISE_EN:  rd = rise_q;
          REG_FALL_EN:  rd = fall_q;
          REG_STATUS:   rd = status_q;
          REG_IRQ_MASK: rd = mask_q;
          default:      rd = '0;
        endcase
        rd &= PIN_MASK;
      end
      CMD_WRITE: begin
        case (reg_idx_t'(b.reg_index))
          REG_DIR:       dir_q = wd;
          REG_LATCH_SET: latch_q |= wd;
          REG_LATCH_CLR: latch_q &= ~wd;
          REG_RISE_EN:   rise_q = wd;
          REG_FALL_EN:   fall_q = wd;
          REG_STATUS:    status_q &= ~wd;
          REG_DIR_SET:   dir_q |= wd;
          REG_DIR_CLR:   dir_q &= ~wd;
          REG_RISE_SET:  rise_q |= wd;
          REG_RISE_CLR:  rise_q &= ~wd;
          REG_FALL_SET:  fall_q |= wd;
          REG_FALL_CLR:  fall_q &= ~wd;
          REG_IRQ_MASK:  mask_q = wd;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.read_data         = rd;
    r.output_levels     = latch_q & PIN_MASK;
    r.output_enables    = dir_q & PIN_MASK;
    r.interrupt_request = |(status_q & mask_q & PIN_MASK);
  endtask

  always @(posedge clk) begin
    gbei_out_t want;
    gbei_out_t got;
    if (!rst_n) begin
      latch_q  = '0;
      dir_q    = '0;
      rise_q   = '0;
      fall_q   = '0;
      status_q = '0;
      mask_q   = '0;
      pins_q   = '0;
      due_results.delete();
    end else begin
      // drain side first, so a stray result is never matched by this edge's beat
      if (out_valid && out_ready) begin
        got = out_data;
        good_cnt++;
        if (got.interrupt_request === 1'b1) irq_cnt++;
        if (due_results.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("[%0t] result beat with nothing expected: rd=%h pad=%h oe=%h irq=%b",
                     $realtime, got.read_data, got.output_levels, got.output_enables,
                     got.interrupt_request);
        end else begin
          want = due_results.pop_front();
          if (got.read_data !== want.read_data ||
              got.output_levels !== want.output_levels ||
              got.output_enables !== want.output_enables ||
              got.interrupt_request !== want.interrupt_request) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("[%0t] exp rd=%h pad=%h oe=%h irq=%b / got rd=%h pad=%h oe=%h irq=%b",
                       $realtime, want.read_data, want.output_levels, want.output_enables,
                       want.interrupt_request, got.read_data, got.output_levels,
                       got.output_enables, got.interrupt_request);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_to_bank(in_data, want);
        due_results.push_back(want);
      end
    end
    mismatches <= bad_cnt;
    waiting    <= due_results.size();
    checked    <= good_cnt;
    irq_seen   <= irq_cnt;
  end

endmodule

FILE: dv/tb_gpio_bank_edge_interrupt_top.sv
// ----------------------------------------------------------------------------
// tb_gpio_bank_edge_interrupt_top
// Drives the gpio bank with a directed sequence over most registers and aliases
// and some edge cases, then a long random mix of ticks, reads and writes in bursts,
// while the result side stalls on its own pattern, once for a long stretch.
// ----------------------------------------------------------------------------
module tb_gpio_bank_edge_interrupt_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gbei_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BEATS = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [3:0]  REG_SPARE_A  = 4'd14;
  localparam logic [3:0]  REG_SPARE_B  = 4'd15;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  gbei_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  gbei_out_t out_data;

  int mismatches, waiting, checked, irq_seen;
  int n_tick, n_read, n_write, n_nop;
  int burst_left;
  int cycle_cnt;
  int rx_mode, rx_left;
  bit hold_go, hold_done;
  logic [DATA_W-1:0] pins_now;

  initial begin
    forever #6 clk = ~clk;
  end

  gpio_bank_edge_interrupt_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  gbei_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .waiting    (waiting),
    .checked    (checked),
    .irq_seen   (irq_seen)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, waiting);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: ready pattern switches between random modes, with one long hold
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // offers one beat, holds it until taken, then maybe idles between bursts
  task automatic send(input cmd_t c, input logic [3:0] idx, input logic [DATA_W-1:0] wd,
                      input logic [DATA_W-1:0] pl);
    gbei_in_t b;
    b.command    = c;
    b.reg_index  = idx;
    b.write_data = wd;
    b.pin_levels = pl;
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    case (c)
      CMD_TICK:  n_tick++;
      CMD_READ:  n_read++;
      CMD_WRITE: n_write++;
      default:   n_nop++;
    endcase
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 250)
                                               : $urandom_range(1, 12);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    logic [DATA_W-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      2:       w = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      3:       w = ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  initial begin
    int r;
    cmd_t c;
    logic [3:0] idx;
    burst_left = 4;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // first tick after reset sees all-zero previous levels: all pins rise
    send(CMD_WRITE, REG_RISE_EN,   32'hFFFF_FFFF, 32'h0);
    send(CMD_WRITE, REG_IRQ_MASK,  32'hFFFF_FFFF, 32'h0);
    send(CMD_TICK,  REG_LEVEL,     32'h0,         32'hFFFF_FFFF);
    send(CMD_READ,  REG_STATUS,    32'h0,         32'h0);
    send(CMD_READ,  REG_LEVEL,     32'h0,         32'h0);
    send(CMD_WRITE, REG_STATUS,    32'h0000_FFFF, 32'h0);
    send(CMD_READ,  REG_STATUS,    32'h0,         32'h0);
    send(CMD_WRITE, REG_FALL_SET,  32'hFFFF_FFFF, 32'h0);
    send(CMD_TICK,  REG_LEVEL,     32'h0,         32'h0);
    send(CMD_WRITE, REG_STATUS,    32'hFFFF_FFFF, 32'h0);
    // level register ignores writes
    send(CMD_WRITE, REG_LEVEL,     32'hFFFF_FFFF, 32'h0);
    send(CMD_READ,  REG_LEVEL,     32'h0,         32'h0);
    send(CMD_WRITE, REG_DIR,       32'hFFFF_FFFF, 32'h0);
    send(CMD_WRITE, REG_DIR_CLR,   32'h0F0F_0F0F, 32'h0);
    send(CMD_WRITE, REG_DIR_SET,   32'h0000_0001, 32'h0);
    send(CMD_READ,  REG_DIR,       32'h0,         32'h0);
    send(CMD_WRITE, REG_LATCH_SET, 32'hFFFF_FFFF, 32'h0);
    send(CMD_WRITE, REG_LATCH_CLR, 32'hAAAA_AAAA, 32'h0);
    // write-only aliases read zero
    send(CMD_READ,  REG_LATCH_SET, 32'h0,         32'h0);
    send(CMD_WRITE, REG_RISE_CLR,  32'hFFFF_FFFF, 32'h0);
    send(CMD_WRITE, REG_FALL_CLR,  32'h5555_5555, 32'h0);
    send(CMD_READ,  REG_FALL_EN,   32'h0,         32'h0);
    send(CMD_WRITE, REG_SPARE_A,   32'hFFFF_FFFF, 32'h0);
    send(CMD_READ,  REG_SPARE_B,   32'h0,         32'h0);
    send(CMD_NOP,   REG_STATUS,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_WRITE, REG_IRQ_MASK,  32'h0,         32'h0);
    pins_now = '0;

    while (n_tick + n_read + n_write < 26 + RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 35)      c = CMD_TICK;
      else if (r < 63) c = CMD_READ;
      else if (r < 96) c = CMD_WRITE;
      else             c = CMD_NOP;
      idx = 4'($urandom_range(0, 15));
      if (c == CMD_TICK) begin
        if ($urandom_range(0, 3) == 0) pins_now = $urandom;
        else pins_now ^= $urandom & $urandom & $urandom;
      end
      if (!hold_go && n_tick + n_read + n_write >= 700) hold_go = 1'b1;
      send(c, idx, pick_word(), (c == CMD_TICK) ? pins_now : $urandom);
    end
    in_valid <= 1'b0;

    // let the checker's count include the last beat taken before polling it
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("sent %0d ticks, %0d reads, %0d writes and %0d idle commands;",
             n_tick, n_read, n_write, n_nop);
    $display("checked %0d result beats, %0d of them with the interrupt raised",
             checked, irq_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d result beats were wrong", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
